// ===== rtl/core/kfsps_pkg.sv =====
// Package with the item types, codes, states and helpers of the keyframe pose sampler.
`default_nettype none
package kfsps_pkg;

    localparam int COORD_BITS = 32;
    localparam int WIDE_BITS  = 66;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_ORDER = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    localparam logic [15:0] MIN_SPAN_RESET = 16'd50;

    localparam logic signed [WIDE_BITS-1:0] COORD_MAX =
        {{(WIDE_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [WIDE_BITS-1:0] COORD_MIN = ~COORD_MAX;

    typedef logic [5:0][COORD_BITS-1:0] t_pose;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [31:0]        time_ms;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] cam_distance;
        logic               curved;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] look_x;
        logic signed [31:0] look_y;
        logic signed [31:0] look_z;
    } t_out_item;

    typedef struct packed {
        logic [31:0] key_time;
        logic        curved;
        t_pose       pose;
    } t_key;

    typedef enum logic [4:0] {
        S_IDLE, S_APP_MUL, S_APP_ACC, S_APP_WR, S_SRCH, S_SRCH_CMP, S_EDGE,
        S_FROM, S_TO, S_PREV, S_NEXT, S_DIV, S_POW1, S_POW2, S_POW3, S_POW4,
        S_MAC, S_ACC, S_OUT
    } t_state;

    function automatic logic [COORD_BITS-1:0] sat_coord(
        input logic signed [WIDE_BITS-1:0] x);
        logic signed [WIDE_BITS-1:0] y;
        begin
            if (x > COORD_MAX) begin
                y = COORD_MAX;
            end else if (x < COORD_MIN) begin
                y = COORD_MIN;
            end else begin
                y = x;
            end
            sat_coord = y[COORD_BITS-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/kfsps_in_if.sv =====
// Input item channel of the keyframe pose sampler.
`default_nettype none
interface kfsps_in_if;
    logic                valid;
    logic                ready;
    kfsps_pkg::t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/kfsps_out_if.sv =====
// Result item channel of the keyframe pose sampler.
`default_nettype none
interface kfsps_out_if;
    logic                 valid;
    logic                 ready;
    kfsps_pkg::t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/kfsps_cfg_if.sv =====
// Configuration write channel carrying the minimum span register.
`default_nettype none
interface kfsps_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/keyframe_spline_pose_sampler_core.sv =====
// Keyframe table with binary search, serial division and spline interpolation.
// Clear and rejected items go straight to the output state; an append uses one multiply per coordinate.
// Sample steps: accept, binary search, final search step, four table reads, 16 division
// steps, the power steps S_POW1 to S_POW4 if curved, a four-term MAC per coordinate, output.
// Items are taken one at a time; a finished result waits in the output register.
// Synchronous reset empties the table and sets the minimum span to 50; no clearing pass.
`default_nettype none
module keyframe_spline_pose_sampler_core #(
    parameter int MAX_KEYS = 64
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    kfsps_in_if.sink        i_in,
    kfsps_out_if.source     o_out,
    kfsps_cfg_if.sink       i_cfg
);
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int WB = kfsps_pkg::WIDE_BITS;

    kfsps_pkg::t_key mem [MAX_KEYS];
    kfsps_pkg::t_key r_rd;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [AW-1:0]   mem_ra;
    kfsps_pkg::t_key mem_wd;

    kfsps_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_count;
    logic [31:0]   r_last_time;
    logic [15:0]   r_min_span;
    kfsps_pkg::t_in_item r_item;
    logic [CW-1:0] r_lo, r_hi;
    logic [CW-1:0] r_mid;
    logic [31:0]   r_t0, r_dur, r_rem;
    logic          r_curved;
    kfsps_pkg::t_pose r_a, r_b, r_p, r_n, r_res;
    logic [15:0]   r_t;
    logic [16:0]   r_t2, r_t3;
    logic [3:0]    r_cnt;
    logic [2:0]    r_c;
    logic [1:0]    r_k;
    logic signed [WB-1:0] r_prod, r_acc;
    logic [1:0]    r_status;
    logic          r_pose_en;
    logic          r_out_valid;
    kfsps_pkg::t_out_item r_out;

    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic [CW-1:0] to_inc;
    logic [CW-1:0] from_idx;
    logic [31:0]   dur_now;
    logic [32:0]   rem2;
    logic          div_ge;
    logic signed [33:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [31:0] dir_c, tg_c;
    logic signed [33:0] val;
    logic signed [19:0] wgt, w_f, w_t, w_hf, w_ht;
    logic signed [19:0] t_s, t2_s, t3_s;
    logic signed [WB-1:0] acc_new, app_pos;
    logic          out_free;
    logic          take_in;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == kfsps_pkg::S_IDLE);
    assign take_in     = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = mid_sum[CW:1];
    assign from_idx = r_lo - CW'(1);
    assign to_inc   = r_lo + CW'(1);
    assign dur_now  = r_rd.key_time - r_t0;
    assign rem2     = {r_rem, 1'b0};
    assign div_ge   = rem2 >= {1'b0, r_dur};

    always_comb begin
        unique case (r_c)
            3'd0:    begin dir_c = r_item.dir_x; tg_c = r_item.target_x; end
            3'd1:    begin dir_c = r_item.dir_y; tg_c = r_item.target_y; end
            default: begin dir_c = r_item.dir_z; tg_c = r_item.target_z; end
        endcase
    end

    assign app_pos = WB'(tg_c) - ((r_prod + WB'(32768)) >>> 16);

    assign t_s  = {4'b0, r_t};
    assign t2_s = {3'b0, r_t2};
    assign t3_s = {3'b0, r_t3};
    assign w_f  = r_curved ? 20'sd2 * (20'sd2 * t3_s - 20'sd3 * t2_s + 20'sd65536)
                           : 20'sd2 * (20'sd65536 - t_s);
    assign w_t  = r_curved ? 20'sd2 * (20'sd3 * t2_s - 20'sd2 * t3_s) : 20'sd2 * t_s;
    assign w_hf = r_curved ? t3_s - 20'sd2 * t2_s + t_s : 20'sd0;
    assign w_ht = r_curved ? t3_s - t2_s : 20'sd0;

    always_comb begin
        case (r_k)
            2'd0: begin
                val = 34'($signed(r_a[r_c]));
                wgt = w_f;
            end
            2'd1: begin
                val = 34'($signed(r_b[r_c]));
                wgt = w_t;
            end
            2'd2: begin
                val = 34'($signed(r_b[r_c])) - 34'($signed(r_p[r_c]));
                wgt = w_hf;
            end
            default: begin
                val = 34'($signed(r_n[r_c])) - 34'($signed(r_a[r_c]));
                wgt = w_ht;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            kfsps_pkg::S_APP_MUL: begin
                mul_a = 34'(dir_c);
                mul_b = r_item.cam_distance;
            end
            kfsps_pkg::S_POW1: begin
                mul_a = {18'b0, r_t};
                mul_b = {16'b0, r_t};
            end
            kfsps_pkg::S_POW3: begin
                mul_a = {17'b0, r_t2};
                mul_b = {16'b0, r_t};
            end
            default: begin
                mul_a = val;
                mul_b = 32'(wgt);
            end
        endcase
    end

    assign acc_new = (r_k == 2'd0) ? r_prod : r_acc + r_prod;

    assign mem_we = (r_state == kfsps_pkg::S_APP_WR);
    assign mem_wa = r_count[AW-1:0];
    assign mem_wd = '{key_time: r_item.time_ms, curved: r_item.curved,
                      pose: {r_item.target_z, r_item.target_y, r_item.target_x,
                             r_res[2], r_res[1], r_res[0]}};

    always_comb begin
        unique case (r_state)
            kfsps_pkg::S_SRCH: begin
                if (r_lo < r_hi) begin
                    mem_ra = mid[AW-1:0];
                end else if (r_lo == '0) begin
                    mem_ra = '0;
                end else if (r_lo == r_count) begin
                    mem_ra = AW'(r_count - CW'(1));
                end else begin
                    mem_ra = from_idx[AW-1:0];
                end
            end
            kfsps_pkg::S_FROM: mem_ra = r_lo[AW-1:0];
            kfsps_pkg::S_TO:   mem_ra = (from_idx == '0) ? AW'(r_count - CW'(1))
                                                          : AW'(from_idx - CW'(1));
            kfsps_pkg::S_PREV: mem_ra = (to_inc == r_count) ? '0 : to_inc[AW-1:0];
            default:           mem_ra = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kfsps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kfsps_pkg::S_IDLE: begin
                if (take_in) begin
                    if (i_in.data.opcode == kfsps_pkg::OP_APPEND && !(r_count != '0
                        && i_in.data.time_ms < r_last_time) && r_count < CW'(MAX_KEYS)) begin
                        n_state = kfsps_pkg::S_APP_MUL;
                    end else if (i_in.data.opcode == kfsps_pkg::OP_SAMPLE && r_count != '0) begin
                        n_state = kfsps_pkg::S_SRCH;
                    end else begin
                        n_state = kfsps_pkg::S_OUT;
                    end
                end
            end
            kfsps_pkg::S_APP_MUL: n_state = kfsps_pkg::S_APP_ACC;
            kfsps_pkg::S_APP_ACC: n_state = (r_c == 3'd2) ? kfsps_pkg::S_APP_WR
                                                          : kfsps_pkg::S_APP_MUL;
            kfsps_pkg::S_APP_WR:  n_state = kfsps_pkg::S_OUT;
            kfsps_pkg::S_SRCH: begin
                if (r_lo < r_hi) begin
                    n_state = kfsps_pkg::S_SRCH_CMP;
                end else if (r_lo == '0 || r_lo == r_count) begin
                    n_state = kfsps_pkg::S_EDGE;
                end else begin
                    n_state = kfsps_pkg::S_FROM;
                end
            end
            kfsps_pkg::S_SRCH_CMP: n_state = kfsps_pkg::S_SRCH;
            kfsps_pkg::S_EDGE:     n_state = kfsps_pkg::S_OUT;
            kfsps_pkg::S_FROM:     n_state = kfsps_pkg::S_TO;
            kfsps_pkg::S_TO:       n_state = (dur_now <= {16'b0, r_min_span})
                                             ? kfsps_pkg::S_OUT : kfsps_pkg::S_PREV;
            kfsps_pkg::S_PREV:     n_state = kfsps_pkg::S_NEXT;
            kfsps_pkg::S_NEXT:     n_state = kfsps_pkg::S_DIV;
            kfsps_pkg::S_DIV: begin
                if (r_cnt == 4'd15) begin
                    n_state = r_curved ? kfsps_pkg::S_POW1 : kfsps_pkg::S_MAC;
                end
            end
            kfsps_pkg::S_POW1: n_state = kfsps_pkg::S_POW2;
            kfsps_pkg::S_POW2: n_state = kfsps_pkg::S_POW3;
            kfsps_pkg::S_POW3: n_state = kfsps_pkg::S_POW4;
            kfsps_pkg::S_POW4: n_state = kfsps_pkg::S_MAC;
            kfsps_pkg::S_MAC:  n_state = kfsps_pkg::S_ACC;
            kfsps_pkg::S_ACC: begin
                if (r_k == 2'd3 && r_c == 3'd5) begin
                    n_state = kfsps_pkg::S_OUT;
                end else begin
                    n_state = kfsps_pkg::S_MAC;
                end
            end
            kfsps_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = kfsps_pkg::S_IDLE;
                end
            end
            default: n_state = kfsps_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_min_span  <= kfsps_pkg::MIN_SPAN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_min_span <= i_cfg.data;
            end
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == kfsps_pkg::S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end
            if (take_in) begin
                if (i_in.data.opcode == kfsps_pkg::OP_CLEAR) begin
                    r_count <= '0;
                end else if (i_in.data.opcode == kfsps_pkg::OP_APPEND && r_count != '0
                             && i_in.data.time_ms < r_last_time) begin
                    r_count <= '0;
                end
            end
            if (mem_we) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (r_state == kfsps_pkg::S_OUT && out_free) begin
            r_out.status <= r_status;
            r_out.pos_x  <= r_pose_en ? r_res[0] : '0;
            r_out.pos_y  <= r_pose_en ? r_res[1] : '0;
            r_out.pos_z  <= r_pose_en ? r_res[2] : '0;
            r_out.look_x <= r_pose_en ? r_res[3] : '0;
            r_out.look_y <= r_pose_en ? r_res[4] : '0;
            r_out.look_z <= r_pose_en ? r_res[5] : '0;
        end
        case (r_state)
            kfsps_pkg::S_IDLE: begin
                r_item    <= i_in.data;
                r_c       <= '0;
                r_k       <= '0;
                r_cnt     <= '0;
                r_lo      <= '0;
                r_hi      <= r_count;
                r_pose_en <= 1'b0;
                r_status  <= kfsps_pkg::STAT_OK;
                if (i_in.data.opcode == kfsps_pkg::OP_APPEND) begin
                    if (r_count != '0 && i_in.data.time_ms < r_last_time) begin
                        r_status <= kfsps_pkg::STAT_ORDER;
                    end else if (r_count >= CW'(MAX_KEYS)) begin
                        r_status <= kfsps_pkg::STAT_FULL;
                    end
                end else if (i_in.data.opcode == kfsps_pkg::OP_SAMPLE && r_count == '0) begin
                    r_status <= kfsps_pkg::STAT_EMPTY;
                end
            end
            kfsps_pkg::S_APP_ACC: begin
                r_res[r_c] <= kfsps_pkg::sat_coord(app_pos);
                r_c        <= r_c + 3'd1;
            end
            kfsps_pkg::S_APP_WR: begin
                r_last_time <= r_item.time_ms;
            end
            kfsps_pkg::S_SRCH: begin
                r_mid <= mid;
            end
            kfsps_pkg::S_SRCH_CMP: begin
                if (r_item.time_ms < r_rd.key_time) begin
                    r_hi <= r_mid;
                end else begin
                    r_lo <= r_mid + CW'(1);
                end
            end
            kfsps_pkg::S_EDGE: begin
                r_res     <= r_rd.pose;
                r_pose_en <= 1'b1;
            end
            kfsps_pkg::S_FROM: begin
                r_a      <= r_rd.pose;
                r_t0     <= r_rd.key_time;
                r_curved <= r_rd.curved;
            end
            kfsps_pkg::S_TO: begin
                r_b       <= r_rd.pose;
                r_dur     <= dur_now;
                r_rem     <= r_item.time_ms - r_t0;
                r_res     <= r_a;
                r_pose_en <= 1'b1;
            end
            kfsps_pkg::S_PREV: begin
                r_p <= r_rd.pose;
            end
            kfsps_pkg::S_NEXT: begin
                r_n <= r_rd.pose;
            end
            kfsps_pkg::S_DIV: begin
                r_rem <= div_ge ? 32'(rem2 - {1'b0, r_dur}) : rem2[31:0];
                r_t   <= {r_t[14:0], div_ge};
                r_cnt <= r_cnt + 4'd1;
            end
            kfsps_pkg::S_POW2: begin
                r_t2 <= 17'((r_prod + WB'(32768)) >>> 16);
            end
            kfsps_pkg::S_POW4: begin
                r_t3 <= 17'((r_prod + WB'(32768)) >>> 16);
            end
            kfsps_pkg::S_ACC: begin
                r_acc <= acc_new;
                r_k   <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_res[r_c] <= kfsps_pkg::sat_coord((acc_new + WB'(65536)) >>> 17);
                    r_c        <= r_c + 3'd1;
                end
            end
            default: begin
            end
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_KEYS))
        else $error("key count beyond table depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_count < CW'(MAX_KEYS)))
        else $error("table write while full");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kfsps_pkg::S_DIV) |-> (r_rem < r_dur))
        else $error("division remainder not below divisor");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kfsps_pkg::S_SRCH_CMP) |-> (r_lo < r_hi))
        else $error("search compare with empty range");

endmodule
`default_nettype wire
